>>> rtl/core/stm_pkg.sv
// Package for the slot table match and min-weight block.
// Holds table size, opcodes, word types and the token that walks the cell chain.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stm_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int OPC_W  = 2;
  localparam int TAG_W  = 8;
  localparam int SLOT_W = 4;
  localparam int LEN_W  = 16;
  localparam int WGT_W  = 64;

  localparam logic [OPC_W-1:0] OP_FIND_FIRST = 2'd0;
  localparam logic [OPC_W-1:0] OP_FIND_LEAST = 2'd1;
  localparam logic [OPC_W-1:0] OP_UPDATE     = 2'd2;

  typedef struct packed {
    logic [OPC_W-1:0]  opcode;
    logic [TAG_W-1:0]  key_tag;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  new_length;
    logic [WGT_W-1:0]  new_weight;
  } in_word_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic [LEN_W-1:0]  hit_length;
  } out_word_t;

  // Query token handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic             vld;
    logic [OPC_W-1:0] op;
    logic [TAG_W-1:0] key;
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [LEN_W-1:0] len;
    logic [WGT_W-1:0] least;
  } tok_t;

  // Slot write broadcast to all cells.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [TAG_W-1:0] tag;
    logic [LEN_W-1:0] len;
    logic [WGT_W-1:0] weight;
  } wr_t;

endpackage

`default_nettype wire

>>> rtl/core/slot_table_match_and_min_weight.sv
// Top level of the slot table: chain of stm_cell slots plus output buffering.
// Depends on stm_pkg and stm_cell.
`timescale 1ns / 1ps
`default_nettype none

// Slot table with tag match and least-weight pick. Each slot lives in its own
// cell; the cells form a chain and a query token steps one cell per clock,
// picking up the first match (opcode find-first) or the strictly lightest
// match (find-least, lowest slot on a tie). An update writes its slot at the
// edge the word is accepted and then runs a token down the chain that yields
// an all-zero result, as do opcode three and updates to a slot past the table.
// One word is in the chain at a time: a result leaves the chain once its
// token has passed through every cell register in order, and the next word
// can be taken in the cycle after the result leaves the chain. A result
// register plus one skid word hold results while the output side stalls;
// the input is held off only while the chain is busy or the skid word is
// occupied. Reset clears every slot to tag, length and weight zero.
module slot_table_match_and_min_weight
  import stm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  tok_t      chain [ENTRIES+1];
  wr_t       wr;
  logic      in_fire;
  logic      out_pop;
  logic      done;
  out_word_t res;

  logic      busy_r, busy_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_r, out_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_word_t skid_r, skid_nxt;

  assign in_ready = !busy_r && !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign out_pop  = out_valid_r && out_ready;

  // Write the named slot right at accept; no query is in flight then.
  always_comb begin
    wr.en     = in_fire && (in_data.opcode == OP_UPDATE) &&
                (32'(in_data.slot) < ENTRIES);
    wr.idx    = IDX_W'(in_data.slot);
    wr.tag    = in_data.key_tag;
    wr.len    = in_data.new_length;
    wr.weight = in_data.new_weight;
  end

  // Inject a fresh token: nothing found, least weight all ones.
  always_comb begin
    chain[0].vld   = in_fire;
    chain[0].op    = in_data.opcode;
    chain[0].key   = in_data.key_tag;
    chain[0].found = 1'b0;
    chain[0].idx   = '0;
    chain[0].len   = '0;
    chain[0].least = '1;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    stm_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_index (IDX_W'(i)),
      .wr         (wr),
      .tok_in     (chain[i]),
      .tok_out    (chain[i+1])
    );
  end

  // Token leaving the last cell carries the result.
  assign done = chain[ENTRIES].vld;

  always_comb begin
    res.hit        = chain[ENTRIES].found;
    res.hit_slot   = chain[ENTRIES].found ? SLOT_W'(chain[ENTRIES].idx) : '0;
    res.hit_length = chain[ENTRIES].found ? chain[ENTRIES].len : '0;
  end

  always_comb begin
    busy_nxt = busy_r;
    if (in_fire) begin
      busy_nxt = 1'b1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end
  end

  // Output register and skid word; skid is always older than a chain result.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (out_pop) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = done;
        skid_nxt       = res;
      end
    end else if (done) begin
      if (!out_valid_r || out_pop) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload: hold without reset.
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

>>> rtl/core/stm_cell.sv
// One slot cell: stores tag, length and weight of one slot and folds it into
// the passing query token. Depends on stm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stm_cell
  import stm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [IDX_W-1:0] cell_index,
  input  wire wr_t              wr,
  input  wire tok_t             tok_in,
  output tok_t                  tok_out
);

  logic [TAG_W-1:0] tag_r;
  logic [LEN_W-1:0] len_r;
  logic [WGT_W-1:0] weight_r;
  tok_t             tok_r;
  tok_t             tok_nxt;
  logic             match;

  assign match = (tag_r == tok_in.key);

  always_comb begin
    tok_nxt = tok_in;
    case (tok_in.op)
      OP_FIND_FIRST: begin
        if (match && !tok_in.found) begin
          tok_nxt.found = 1'b1;
          tok_nxt.idx   = cell_index;
          tok_nxt.len   = len_r;
        end
      end
      OP_FIND_LEAST: begin
        // strict compare: lowest slot wins a tie, all-ones never wins
        if (match && (weight_r < tok_in.least)) begin
          tok_nxt.found = 1'b1;
          tok_nxt.idx   = cell_index;
          tok_nxt.len   = len_r;
          tok_nxt.least = weight_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r     <= '0;
      len_r     <= '0;
      weight_r  <= '0;
      tok_r     <= '0;
    end else begin
      tok_r <= tok_nxt;
      if (wr.en && (wr.idx == cell_index)) begin
        tag_r    <= wr.tag;
        len_r    <= wr.len;
        weight_r <= wr.weight;
      end
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

>>> rtl/core/stm_checker.sv
// Port-level checker for slot_table_match_and_min_weight, bound to the top.
// Depends on stm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stm_checker
  import stm_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_word_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed or dropped");

  // Accepting a word makes the block busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted twice in a row");

  // A miss reports slot and length zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.hit) |->
      ((out_data.hit_slot == '0) && (out_data.hit_length == '0)))
    else $error("miss with nonzero slot or length");

  // With the output empty, a result shows after the full chain walk.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !out_valid) |-> ##(ENTRIES+1) out_valid)
    else $error("result missing after chain latency");

  // An update never comes back as a hit when it is the only word in flight.
  a_update_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !out_valid && (in_data.opcode == OP_UPDATE)) |->
      ##(ENTRIES+1) !out_data.hit)
    else $error("update produced a hit");

endmodule

bind slot_table_match_and_min_weight stm_checker u_stm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
